// ===== sv/thtag_pkg.sv =====
// Shared types and constants for the tiled H/C transpose address generator.
`timescale 1ns / 1ps

package thtag_pkg;

    // Field widths.
    localparam int CNT_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int TILE_IDX_W = 21;
    localparam int OFFSET_W   = 12;
    localparam int LINE_W     = 6;
    localparam int H_LOW_W    = 5;

    // Stream payload widths and positions.
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 40;
    localparam int LINE_LSB    = TILE_IDX_W + OFFSET_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_H         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BYTES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_BYTES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT32_MODE   = 3'd5;

    // Last line of a tile and the h row that closes a 32-row tile band.
    localparam logic [LINE_W-1:0]  LINE_LAST  = 6'd63;
    localparam logic [H_LOW_W-1:0] H_LOW_LAST = 5'd31;

    // Item operation carried on the input tuser.
    typedef enum logic {
        OP_SEEK = 1'b0,
        OP_NEXT = 1'b1
    } t_op;

    // Configuration register set.
    typedef struct packed {
        logic [CNT_W-1:0]  tiles_across_w;
        logic [CNT_W-1:0]  rows_h;
        logic [CNT_W-1:0]  tiles_across_c;
        logic [ADDR_W-1:0] plane_bytes;
        logic [ADDR_W-1:0] batch_bytes;
        logic              float32_mode;
    } t_cfg;

    // Walk position through the source tensor.
    typedef struct packed {
        logic [CNT_W-1:0]  row_h;
        logic [ADDR_W-1:0] row_tile_base;
        logic [CNT_W-1:0]  c_tile;
        logic [ADDR_W-1:0] c_byte_offset;
        logic [CNT_W-1:0]  w_tile;
        logic [ADDR_W-1:0] batch_base;
    } t_pos;

    // Prepared tile bases handed to the line generator.
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] base0;
        logic [ADDR_W-1:0] base1;
    } t_handoff;

endpackage

// ===== sv/tiled_hc_transpose_address_gen_unit.sv =====
// Top level of the tiled H/C transpose source address generator.
`timescale 1ns / 1ps

// A seek item loads the walk position and produces nothing. A next item produces
// 64 line addresses, one per cycle while the output is not stalled, in subtile
// order 0..3 with the sixteen channel lines of each subtile in turn; an item passes
// base stages P, B and C and the walk registers before its first line reaches the
// output register. The input side takes the next item while the lines of earlier
// ones are still being sent, so a stream of next items is paced by the line
// generator's single address adder. Downstream stalls hold the current line and
// pause the walk. Configuration is written through a plain write port and must
// only change while the block is idle.

module tiled_hc_transpose_address_gen_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_wr_en,
    input  logic [thtag_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [thtag_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input items.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // start_h, start_row_tile_base, start_c_tile, start_c_offset,
    // start_w_tile, start_batch_base
    input  logic [thtag_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // operation
    input  logic                                  i_s_axis_tuser,
    // Result items.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tile_index, offset_in_tile, line_number, zero pad
    output logic [thtag_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // last_line
    output logic                                  o_m_axis_tlast
);

    thtag_pkg::t_cfg      cfg;
    thtag_pkg::t_pos      pos;
    thtag_pkg::t_pos      start;
    thtag_pkg::t_handoff  handoff;
    thtag_pkg::t_op       op;

    logic                               in_ready;
    logic                               in_accept;
    logic                               accept_seek;
    logic                               accept_next;
    logic                               take;
    logic [thtag_pkg::TILE_IDX_W-1:0]   tile_index;
    logic [thtag_pkg::OFFSET_W-1:0]     offset_in_tile;
    logic [thtag_pkg::LINE_W-1:0]       line_number;

    // Input item decode.
    always_comb begin
        op                  = thtag_pkg::t_op'(i_s_axis_tuser);
        in_accept           = i_s_axis_tvalid && in_ready;
        accept_seek         = in_accept && (op == thtag_pkg::OP_SEEK);
        accept_next         = in_accept && (op == thtag_pkg::OP_NEXT);
        start.row_h         = i_s_axis_tdata[15:0];
        start.row_tile_base = i_s_axis_tdata[47:16];
        start.c_tile        = i_s_axis_tdata[63:48];
        start.c_byte_offset = i_s_axis_tdata[95:64];
        start.w_tile        = i_s_axis_tdata[111:96];
        start.batch_base    = i_s_axis_tdata[143:112];
    end

    thtag_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    thtag_position u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_seek    (accept_seek),
        .i_advance (accept_next),
        .i_start   (start),
        .o_pos     (pos)
    );

    thtag_base_pipe u_base (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept_next (accept_next),
        .i_pos         (pos),
        .i_take        (take),
        .o_ready       (in_ready),
        .o_handoff     (handoff)
    );

    thtag_line_gen u_gen (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_handoff        (handoff),
        .o_take           (take),
        .i_m_ready        (i_m_axis_tready),
        .o_vld            (o_m_axis_tvalid),
        .o_tile_index     (tile_index),
        .o_offset_in_tile (offset_in_tile),
        .o_line_number    (line_number),
        .o_last_line      (o_m_axis_tlast)
    );

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tdata  = {1'b0, line_number, offset_in_tile, tile_index};

endmodule

// ===== sv/thtag_cfg_regs.sv =====
// Configuration register file of the transpose address generator.
`timescale 1ns / 1ps

module thtag_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [thtag_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [thtag_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output thtag_pkg::t_cfg                     o_cfg
);

    thtag_pkg::t_cfg r_cfg;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tiles_across_w <= 16'd1;
            r_cfg.rows_h         <= 16'd1;
            r_cfg.tiles_across_c <= 16'd1;
            r_cfg.plane_bytes    <= '0;
            r_cfg.batch_bytes    <= '0;
            r_cfg.float32_mode   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                thtag_pkg::CFG_TILES_ACROSS_W: begin
                    r_cfg.tiles_across_w <= i_cfg_data[thtag_pkg::CNT_W-1:0];
                end
                thtag_pkg::CFG_ROWS_H: begin
                    r_cfg.rows_h <= i_cfg_data[thtag_pkg::CNT_W-1:0];
                end
                thtag_pkg::CFG_TILES_ACROSS_C: begin
                    r_cfg.tiles_across_c <= i_cfg_data[thtag_pkg::CNT_W-1:0];
                end
                thtag_pkg::CFG_PLANE_BYTES: begin
                    r_cfg.plane_bytes <= i_cfg_data;
                end
                thtag_pkg::CFG_BATCH_BYTES: begin
                    r_cfg.batch_bytes <= i_cfg_data;
                end
                thtag_pkg::CFG_FLOAT32_MODE: begin
                    r_cfg.float32_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/thtag_position.sv =====
// Position counters: loaded by a seek item, advanced after each next item.
`timescale 1ns / 1ps

module thtag_position (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  thtag_pkg::t_cfg i_cfg,
    input  logic            i_seek,
    input  logic            i_advance,
    input  thtag_pkg::t_pos i_start,
    output thtag_pkg::t_pos o_pos
);

    thtag_pkg::t_pos r_pos;
    thtag_pkg::t_pos n_pos;

    logic [thtag_pkg::CNT_W-1:0]  w_inc;
    logic [thtag_pkg::CNT_W-1:0]  c_inc;
    logic [thtag_pkg::CNT_W-1:0]  h_inc;
    logic [thtag_pkg::ADDR_W-1:0] c_offset_inc;
    logic                         w_wrap;
    logic                         c_wrap;
    logic                         h_wrap;

    // Counters step w first, then c, then h; each wraps when it meets its register.
    always_comb begin
        w_inc        = r_pos.w_tile + 16'd1;
        c_inc        = r_pos.c_tile + 16'd1;
        h_inc        = r_pos.row_h + 16'd1;
        c_offset_inc = r_pos.c_byte_offset + {i_cfg.plane_bytes[26:0], 5'd0};
        w_wrap       = (w_inc == i_cfg.tiles_across_w);
        c_wrap       = (c_inc == i_cfg.tiles_across_c);
        h_wrap       = (h_inc == i_cfg.rows_h);

        n_pos = r_pos;
        if (!w_wrap) begin
            n_pos.w_tile = w_inc;
        end else begin
            n_pos.w_tile = '0;
            if (!c_wrap) begin
                n_pos.c_tile        = c_inc;
                n_pos.c_byte_offset = c_offset_inc;
            end else begin
                n_pos.c_tile        = '0;
                n_pos.c_byte_offset = '0;
                if (h_wrap) begin
                    n_pos.row_h         = '0;
                    n_pos.row_tile_base = '0;
                    n_pos.batch_base    = r_pos.batch_base + i_cfg.batch_bytes;
                end else begin
                    n_pos.row_h = h_inc;
                    // A finished 32-row band moves to the next row of tiles.
                    if (r_pos.row_h[thtag_pkg::H_LOW_W-1:0] == thtag_pkg::H_LOW_LAST) begin
                        n_pos.row_tile_base = r_pos.row_tile_base
                                            + {16'd0, i_cfg.tiles_across_w};
                    end
                end
            end
        end
    end

    // Position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_seek) begin
            r_pos <= i_start;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

// ===== sv/thtag_base_pipe.sv =====
// Three-stage pipeline that forms the two subtile base addresses of a tile.
`timescale 1ns / 1ps

module thtag_base_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  thtag_pkg::t_cfg    i_cfg,
    input  logic               i_accept_next,
    input  thtag_pkg::t_pos    i_pos,
    input  logic               i_take,
    output logic               o_ready,
    output thtag_pkg::t_handoff o_handoff
);

    // Stage P: partial sums captured from the position at acceptance.
    logic                           r_p_vld;
    logic [thtag_pkg::ADDR_W-1:0]   r_p_sum;
    logic [thtag_pkg::ADDR_W-1:0]   r_p_tile;
    logic [thtag_pkg::H_LOW_W-1:0]  r_p_hlow;
    // Stage B: tile base of subtile 0.
    logic                           r_b_vld;
    logic [thtag_pkg::ADDR_W-1:0]   r_b_base;
    // Stage C: bases of even and odd subtiles.
    logic                           r_c_vld;
    logic [thtag_pkg::ADDR_W-1:0]   r_c_base0;
    logic [thtag_pkg::ADDR_W-1:0]   r_c_base1;

    logic                           c_free;
    logic                           b_move;
    logic                           b_free;
    logic                           p_move;
    logic [thtag_pkg::ADDR_W-1:0]   tile_term;
    logic [thtag_pkg::OFFSET_W-1:0] h_term;
    logic [thtag_pkg::ADDR_W-1:0]   n_b_base;
    logic [thtag_pkg::ADDR_W-1:0]   sub_step;

    // Stage flow control.
    always_comb begin
        c_free  = !r_c_vld || i_take;
        b_move  = r_b_vld && c_free;
        b_free  = !r_b_vld || b_move;
        p_move  = r_p_vld && b_free;
        o_ready = !r_p_vld || p_move;
    end

    // The shifted tile term has zero low bits, so the row term is merged by OR.
    always_comb begin
        if (i_cfg.float32_mode) begin
            tile_term = {r_p_tile[19:0], 12'd0};
            h_term    = {r_p_hlow[4], 1'b0, r_p_hlow[3:0], 6'd0};
            sub_step  = 32'd1 << 10;
        end else begin
            tile_term = {r_p_tile[20:0], 11'd0};
            h_term    = {1'b0, r_p_hlow[4], 1'b0, r_p_hlow[3:0], 5'd0};
            sub_step  = 32'd1 << 9;
        end
        n_b_base = r_p_sum + (tile_term | {20'd0, h_term});
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (i_accept_next) begin
                r_p_vld <= 1'b1;
            end else if (p_move) begin
                r_p_vld <= 1'b0;
            end
            if (p_move) begin
                r_b_vld <= 1'b1;
            end else if (b_move) begin
                r_b_vld <= 1'b0;
            end
            if (b_move) begin
                r_c_vld <= 1'b1;
            end else if (i_take) begin
                r_c_vld <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_accept_next) begin
            r_p_sum  <= i_pos.batch_base + i_pos.c_byte_offset;
            r_p_tile <= i_pos.row_tile_base + {16'd0, i_pos.w_tile};
            r_p_hlow <= i_pos.row_h[thtag_pkg::H_LOW_W-1:0];
        end
        if (p_move) begin
            r_b_base <= n_b_base;
        end
        if (b_move) begin
            r_c_base0 <= r_b_base;
            r_c_base1 <= r_b_base + sub_step;
        end
    end

    assign o_handoff.vld   = r_c_vld;
    assign o_handoff.base0 = r_c_base0;
    assign o_handoff.base1 = r_c_base1;

endmodule

// ===== sv/thtag_line_gen.sv =====
// Line generator: walks the 64 subtile lines of a tile into the output register.
`timescale 1ns / 1ps

module thtag_line_gen (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  thtag_pkg::t_cfg                      i_cfg,
    input  thtag_pkg::t_handoff                  i_handoff,
    output logic                                 o_take,
    input  logic                                 i_m_ready,
    output logic                                 o_vld,
    output logic [thtag_pkg::TILE_IDX_W-1:0]     o_tile_index,
    output logic [thtag_pkg::OFFSET_W-1:0]       o_offset_in_tile,
    output logic [thtag_pkg::LINE_W-1:0]         o_line_number,
    output logic                                 o_last_line
);

    logic                              r_g_vld;
    logic [thtag_pkg::LINE_W-1:0]      r_g_line;
    logic [thtag_pkg::ADDR_W-1:0]      r_g_base0;
    logic [thtag_pkg::ADDR_W-1:0]      r_g_base1;
    logic [thtag_pkg::ADDR_W-1:0]      r_g_cacc;

    logic                              r_o_vld;
    logic [thtag_pkg::TILE_IDX_W-1:0]  r_o_tile;
    logic [thtag_pkg::OFFSET_W-1:0]    r_o_offset;
    logic [thtag_pkg::LINE_W-1:0]      r_o_line;
    logic                              r_o_last;

    logic                              gen_fire;
    logic                              gen_last;
    logic [thtag_pkg::ADDR_W-1:0]      line_addr;
    logic [thtag_pkg::ADDR_W-1:0]      n_cacc;
    logic [thtag_pkg::TILE_IDX_W-1:0]  n_tile;
    logic [thtag_pkg::OFFSET_W-1:0]    n_offset;

    // A line moves out when the output register is empty or being drained.
    always_comb begin
        gen_fire = r_g_vld && (!r_o_vld || i_m_ready);
        gen_last = (r_g_line == thtag_pkg::LINE_LAST);
        o_take   = i_handoff.vld && (!r_g_vld || (gen_fire && gen_last));
    end

    // Odd subtiles use the second base; the channel offset runs inside each subtile.
    always_comb begin
        line_addr = (r_g_line[4] ? r_g_base1 : r_g_base0) + r_g_cacc;
        if (r_g_line[3:0] == 4'hF) begin
            // Subtiles 2 and 3 start sixteen channel planes further on.
            n_cacc = (r_g_line[5] ^ r_g_line[4]) ? {i_cfg.plane_bytes[27:0], 4'd0} : '0;
        end else begin
            n_cacc = r_g_cacc + i_cfg.plane_bytes;
        end
        if (i_cfg.float32_mode) begin
            n_tile   = {1'b0, line_addr[31:12]};
            n_offset = line_addr[11:0];
        end else begin
            n_tile   = line_addr[31:11];
            n_offset = {1'b0, line_addr[10:0]};
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_g_vld <= 1'b1;
            end else if (gen_fire && gen_last) begin
                r_g_vld <= 1'b0;
            end
            if (gen_fire) begin
                r_o_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Walk registers and the output register.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_g_base0 <= i_handoff.base0;
            r_g_base1 <= i_handoff.base1;
            r_g_cacc  <= '0;
            r_g_line  <= '0;
        end else if (gen_fire) begin
            r_g_cacc <= n_cacc;
            r_g_line <= r_g_line + 6'd1;
        end
        if (gen_fire) begin
            r_o_tile   <= n_tile;
            r_o_offset <= n_offset;
            r_o_line   <= r_g_line;
            r_o_last   <= gen_last;
        end
    end

    assign o_vld            = r_o_vld;
    assign o_tile_index     = r_o_tile;
    assign o_offset_in_tile = r_o_offset;
    assign o_line_number    = r_o_line;
    assign o_last_line      = r_o_last;

endmodule

// ===== sv/thtag_checker.sv =====
// Port-level checks of the transpose address generator and their binding.
`timescale 1ns / 1ps

module thtag_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [thtag_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                               o_m_axis_tlast
);

    logic                          in_next;
    logic                          out_acc;
    logic [thtag_pkg::LINE_W-1:0]  out_line;
    logic [thtag_pkg::LINE_W-1:0]  r_exp_line;
    // Wide enough for four tiles of lines in flight.
    logic [9:0]                    r_owed;

    always_comb begin
        in_next  = i_s_axis_tvalid && o_s_axis_tready
                && (thtag_pkg::t_op'(i_s_axis_tuser) == thtag_pkg::OP_NEXT);
        out_acc  = o_m_axis_tvalid && i_m_axis_tready;
        out_line = o_m_axis_tdata[thtag_pkg::LINE_LSB +: thtag_pkg::LINE_W];
    end

    // Expected line number and count of lines still owed to the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_line <= '0;
            r_owed     <= '0;
        end else begin
            if (out_acc) begin
                r_exp_line <= r_exp_line + 6'd1;
            end
            r_owed <= r_owed + (in_next ? 10'd64 : 10'd0) - (out_acc ? 10'd1 : 10'd0);
        end
    end

    // Lines leave in strict order 0..63 across tiles.
    a_line_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (out_line == r_exp_line))
        else $error("line number out of order");

    // The tile end flag marks exactly the 64th line.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (out_line == thtag_pkg::LINE_LAST)))
        else $error("last flag does not match line number");

    // No line appears that no next item asked for.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_owed != '0))
        else $error("result without a pending next item");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind tiled_hc_transpose_address_gen_unit thtag_checker u_thtag_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
